@@ hdl/bapg_pkg.sv @@
// Shared types and constants for the buzzer alert pattern generator.
package bapg_pkg;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_GREETING  = 3'd1,
      OP_SIREN     = 3'd2,
      OP_COUNTDOWN = 3'd3,
      OP_BLINDSPOT = 3'd4,
      OP_STOP      = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      MODE_SILENT    = 3'd0,
      MODE_GREETING  = 3'd1,
      MODE_SIREN     = 3'd2,
      MODE_COUNTDOWN = 3'd3,
      MODE_BLINDSPOT = 3'd4
   } mode_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      logic        tone_on;
      logic [11:0] frequency_hz;
      logic [2:0]  mode;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] start_time;
      logic [10:0] sweep_freq;
      logic        sweep_rising;
      logic [31:0] last_sweep_time;
      logic        tone_active;
      logic [11:0] tone_freq;
   } state_type;

   // time-of-window flags, worked out ahead of the state update
   typedef struct packed {
      logic countdown_on;
      logic blindspot_on;
   } phase_type;

   localparam logic [31:0] GREET_STEP1_MS = 32'd150;
   localparam logic [31:0] GREET_STEP2_MS = 32'd300;
   localparam logic [31:0] GREET_STEP3_MS = 32'd450;
   localparam logic [11:0] GREET_FREQ1    = 12'd1200;
   localparam logic [11:0] GREET_FREQ2    = 12'd2000;
   localparam logic [11:0] GREET_FREQ3    = 12'd2500;

   localparam logic [10:0] SWEEP_LOW      = 11'd800;
   localparam logic [10:0] SWEEP_HIGH     = 11'd1500;
   localparam logic [10:0] SWEEP_STEP     = 11'd50;
   localparam logic [31:0] SWEEP_GAP_MS   = 32'd15;

   localparam logic [11:0] COUNTDOWN_FREQ = 12'd3000;
   localparam logic [9:0]  COUNTDOWN_ON_MS = 10'd50;
   localparam logic [11:0] BLINDSPOT_FREQ = 12'd2200;
   localparam logic [9:0]  CHIRP1_END_MS  = 10'd60;
   localparam logic [9:0]  CHIRP2_BEG_MS  = 10'd120;
   localparam logic [9:0]  CHIRP2_END_MS  = 10'd180;

   // time mod 1000 = ((time >> 3) mod 125) * 8 + time[2:0]
   // time mod 600  = ((time >> 3) mod 75)  * 8 + time[2:0]
   localparam int          CD_DIV      = 125;
   localparam int          BS_DIV      = 75;
   localparam int          RECIP_SHIFT = 36;
   localparam logic [29:0] CD_RECIP    = 30'd549755813;  // floor(2^36 / 125)
   localparam logic [29:0] BS_RECIP    = 30'd916259689;  // floor(2^36 / 75)

endpackage

@@ hdl/bapg_step.sv @@
// Next-state logic for one item: command decode and per-mode tone pattern.
module bapg_step
   import bapg_pkg::*;
(
   input  state_type state_cur,
   input  req_type   item,
   input  phase_type phase,
   output state_type state_nxt
);

   logic [31:0] greet_elapsed;
   logic [31:0] sweep_elapsed;
   logic [11:0] sweep_up;
   logic [10:0] sweep_down;

   assign greet_elapsed = item.time_ms - state_cur.start_time;
   assign sweep_elapsed = item.time_ms - state_cur.last_sweep_time;
   assign sweep_up      = {1'b0, state_cur.sweep_freq} + {1'b0, SWEEP_STEP};
   assign sweep_down    = state_cur.sweep_freq - SWEEP_STEP;

   always_comb begin
      state_nxt = state_cur;
      case (op_type'(item.operation))
         OP_TICK: begin
            case (state_cur.mode)
               MODE_GREETING: begin
                  state_nxt.tone_active = 1'b1;
                  if (greet_elapsed < GREET_STEP1_MS) begin
                     state_nxt.tone_freq = GREET_FREQ1;
                  end else if (greet_elapsed < GREET_STEP2_MS) begin
                     state_nxt.tone_freq = GREET_FREQ2;
                  end else if (greet_elapsed < GREET_STEP3_MS) begin
                     state_nxt.tone_freq = GREET_FREQ3;
                  end else begin
                     state_nxt.mode        = MODE_SILENT;
                     state_nxt.tone_active = 1'b0;
                     state_nxt.tone_freq   = '0;
                  end
               end
               MODE_SIREN: begin
                  if (sweep_elapsed > SWEEP_GAP_MS) begin
                     state_nxt.last_sweep_time = item.time_ms;
                     state_nxt.tone_active     = 1'b1;
                     if (state_cur.sweep_rising) begin
                        state_nxt.sweep_freq = sweep_up[10:0];
                        state_nxt.tone_freq  = {1'b0, sweep_up[10:0]};
                        if (sweep_up >= {1'b0, SWEEP_HIGH}) begin
                           state_nxt.sweep_rising = 1'b0;
                        end
                     end else begin
                        state_nxt.sweep_freq = sweep_down;
                        state_nxt.tone_freq  = {1'b0, sweep_down};
                        if (sweep_down <= SWEEP_LOW) begin
                           state_nxt.sweep_rising = 1'b1;
                        end
                     end
                  end
               end
               MODE_COUNTDOWN: begin
                  state_nxt.tone_active = phase.countdown_on;
                  state_nxt.tone_freq   = phase.countdown_on ? COUNTDOWN_FREQ : '0;
               end
               MODE_BLINDSPOT: begin
                  state_nxt.tone_active = phase.blindspot_on;
                  state_nxt.tone_freq   = phase.blindspot_on ? BLINDSPOT_FREQ : '0;
               end
               default: begin
                  state_nxt.tone_active = 1'b0;
                  state_nxt.tone_freq   = '0;
               end
            endcase
         end
         OP_GREETING: begin
            state_nxt.mode       = MODE_GREETING;
            state_nxt.start_time = item.time_ms;
         end
         OP_SIREN: begin
            if (state_cur.mode != MODE_SIREN) begin
               state_nxt.mode       = MODE_SIREN;
               state_nxt.sweep_freq = SWEEP_LOW;
            end
         end
         OP_COUNTDOWN: begin
            state_nxt.mode = MODE_COUNTDOWN;
         end
         OP_BLINDSPOT: begin
            state_nxt.mode = MODE_BLINDSPOT;
         end
         OP_STOP: begin
            state_nxt.mode        = MODE_SILENT;
            state_nxt.tone_active = 1'b0;
            state_nxt.tone_freq   = '0;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

@@ hdl/buzzer_alert_pattern_generator.sv @@
// Top level of the buzzer alert pattern generator.
//
// Usage:
//   req_* carries one item per handshake: a tick with the current millisecond
//   time, or a command (start greeting, siren, countdown, blindspot, or stop).
//   rsp_* returns exactly one item per request: tone on/off, the tone
//   frequency in hertz (0 when off) and the mode after the request.
//   An item moves when valid is high and stall is low.
// Timing:
//   Three register stages: the reciprocal products for time mod 1000 and
//   time mod 600, then the window flags, then the pattern state update into
//   the result register, which each request passes through in that order;
//   one item is accepted every cycle while rsp_stall is low.
// Stall:
//   rsp_stall holds the result register; the stages behind it fill, and
//   req_stall rises only once both stages behind the result are full.
// Reset:
//   Synchronous, active high. Pipeline empties, mode returns to silent, the
//   tone goes off and the siren sweep restarts at 800 Hz rising.
module buzzer_alert_pattern_generator
   import bapg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic out_ready;
   logic s2_ready;
   logic s1_ready;
   logic req_accept;

   logic        s1_v_ff, s1_v_in;
   req_type     s1_req_ff, s1_req_in;
   logic [22:0] s1_qcd_ff, s1_qcd_in;
   logic [22:0] s1_qbs_ff, s1_qbs_in;

   logic        s2_v_ff, s2_v_in;
   req_type     s2_req_ff, s2_req_in;
   phase_type   s2_phase_ff, s2_phase_in;

   state_type   state_ff, state_in;
   state_type   state_nxt;
   logic        rsp_v_ff, rsp_v_in;
   rsp_type     rsp_ff, rsp_in;

   logic [58:0] cd_prod;
   logic [58:0] bs_prod;
   logic [28:0] cd_rem_full;
   logic [28:0] bs_rem_full;
   logic [7:0]  cd_r;
   logic [7:0]  bs_r;
   logic [7:0]  cd_rem;
   logic [7:0]  bs_rem;
   logic [9:0]  cd_mod;
   logic [9:0]  bs_mod;

   assign out_ready  = !rsp_v_ff || !rsp_stall;
   assign s2_ready   = !s2_v_ff || out_ready;
   assign s1_ready   = !s1_v_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   // quotient estimates, low by at most one
   assign cd_prod = {30'd0, req_payload.time_ms[31:3]} * {29'd0, CD_RECIP};
   assign bs_prod = {30'd0, req_payload.time_ms[31:3]} * {29'd0, BS_RECIP};

   always_comb begin
      s1_v_in   = s1_ready ? req_valid : s1_v_ff;
      s1_req_in = req_accept ? req_payload : s1_req_ff;
      s1_qcd_in = req_accept ? cd_prod[RECIP_SHIFT +: 23] : s1_qcd_ff;
      s1_qbs_in = req_accept ? bs_prod[RECIP_SHIFT +: 23] : s1_qbs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
      s1_req_ff <= s1_req_in;
      s1_qcd_ff <= s1_qcd_in;
      s1_qbs_ff <= s1_qbs_in;
   end

   assign cd_rem_full = s1_req_ff.time_ms[31:3] - ({6'd0, s1_qcd_ff} * 29'(CD_DIV));
   assign bs_rem_full = s1_req_ff.time_ms[31:3] - ({6'd0, s1_qbs_ff} * 29'(BS_DIV));
   assign cd_r        = cd_rem_full[7:0];
   assign bs_r        = bs_rem_full[7:0];
   assign cd_rem      = (cd_r >= 8'(CD_DIV)) ? cd_r - 8'(CD_DIV) : cd_r;
   assign bs_rem      = (bs_r >= 8'(BS_DIV)) ? bs_r - 8'(BS_DIV) : bs_r;
   assign cd_mod      = {cd_rem[6:0], s1_req_ff.time_ms[2:0]};
   assign bs_mod      = {bs_rem[6:0], s1_req_ff.time_ms[2:0]};

   always_comb begin
      s2_v_in     = s2_ready ? s1_v_ff : s2_v_ff;
      s2_req_in   = s2_req_ff;
      s2_phase_in = s2_phase_ff;
      if (s2_ready && s1_v_ff) begin
         s2_req_in                = s1_req_ff;
         s2_phase_in.countdown_on = cd_mod < COUNTDOWN_ON_MS;
         s2_phase_in.blindspot_on = (bs_mod < CHIRP1_END_MS) ||
                                    ((bs_mod >= CHIRP2_BEG_MS) && (bs_mod < CHIRP2_END_MS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
      end
      s2_req_ff   <= s2_req_in;
      s2_phase_ff <= s2_phase_in;
   end

   bapg_step u_step (
      .state_cur (state_ff),
      .item      (s2_req_ff),
      .phase     (s2_phase_ff),
      .state_nxt (state_nxt)
   );

   always_comb begin
      rsp_v_in = out_ready ? s2_v_ff : rsp_v_ff;
      state_in = state_ff;
      rsp_in   = rsp_ff;
      if (out_ready && s2_v_ff) begin
         state_in            = state_nxt;
         rsp_in.tone_on      = state_nxt.tone_active;
         rsp_in.frequency_hz = state_nxt.tone_active ? state_nxt.tone_freq : '0;
         rsp_in.mode         = state_nxt.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff                <= 1'b0;
         state_ff.mode           <= MODE_SILENT;
         state_ff.start_time     <= '0;
         state_ff.sweep_freq     <= SWEEP_LOW;
         state_ff.sweep_rising   <= 1'b1;
         state_ff.last_sweep_time <= '0;
         state_ff.tone_active    <= 1'b0;
         state_ff.tone_freq      <= '0;
      end else begin
         rsp_v_ff <= rsp_v_in;
         state_ff <= state_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_v_ff && !s1_v_ff && !s2_v_ff))
      else $error("pipeline not empty after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_v_ff)
      else $error("accepted item missing from first stage");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.sweep_freq >= 11'd750) && (state_ff.sweep_freq <= SWEEP_HIGH))
      else $error("siren sweep out of range");

   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      !state_ff.tone_active |-> (state_ff.tone_freq == 12'd0))
      else $error("tone off with nonzero frequency");
`endif

endmodule
